>>> hw/rtl/uigf_pkg.sv
// Shared constants, codes and types of the idle-gap frame receiver.
package uigf_pkg;

    // Frame store size, derived address width and field widths
    localparam int BufferDepth = 64;
    localparam int AddrW       = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
    localparam int IdxW        = 7;
    localparam int ByteW       = 8;
    localparam int CmdW        = 2;
    localparam int KindW       = 2;

    localparam logic [ByteW-1:0] IdleTimeoutReset = 8'd30;

    // Input commands
    localparam logic [CmdW-1:0] CmdRxByte = 2'd0;
    localparam logic [CmdW-1:0] CmdTick   = 2'd1;
    localparam logic [CmdW-1:0] CmdRead   = 2'd2;

    // Result kinds
    localparam logic [KindW-1:0] KindData   = 2'd0;
    localparam logic [KindW-1:0] KindNotice = 2'd1;
    localparam logic [KindW-1:0] KindEmpty  = 2'd2;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] data;
        logic             last;
        logic [IdxW-1:0]  length;
        logic             overflow;
    } t_result;

endpackage

>>> hw/rtl/uigf_if.sv
// Handshake channels of the idle-gap frame receiver: input word, result word, config write.
interface uigf_in_if;
    logic                         valid;
    logic                         ready;
    logic [uigf_pkg::CmdW-1:0]    command;
    logic [uigf_pkg::ByteW-1:0]   rx_byte;
    logic [uigf_pkg::ByteW-1:0]   tick_ms;
    logic [uigf_pkg::IdxW-1:0]    read_limit;

    modport source (output valid, command, rx_byte, tick_ms, read_limit, input ready);
    modport sink   (input valid, command, rx_byte, tick_ms, read_limit, output ready);
endinterface

interface uigf_out_if;
    logic                         valid;
    logic                         ready;
    logic [uigf_pkg::KindW-1:0]   kind;
    logic [uigf_pkg::ByteW-1:0]   data;
    logic                         last;
    logic [uigf_pkg::IdxW-1:0]    length;
    logic                         overflow;

    modport source (output valid, kind, data, last, length, overflow, input ready);
    modport sink   (input valid, kind, data, last, length, overflow, output ready);
endinterface

interface uigf_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [uigf_pkg::ByteW-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/uart_idle_gap_frame_receiver_top.sv
// Top level of the UART idle-gap frame receiver: config register and control core.
//
// Collects received UART bytes into a 64-byte frame store and reports a frame as
// complete once the line has been idle longer than the idle timeout register
// (reset value 30 ms). Each input word carries a command: received byte (stored,
// or dropped with a sticky overflow flag once the store is full), millisecond
// tick (advances an 8-bit wrapping idle counter while a frame is open and emits
// one frame-complete notice when the timeout is exceeded), or read (streams up
// to read_limit stored bytes, last marked, or one empty-read word when there is
// nothing to give, and rewinds the write index). A byte or tick word is accepted
// whenever the result register is free and no readout is running. During a read
// the readout walks the frame store through its single registered read port, one
// byte per cycle while the sink keeps up, and no input word is taken until
// the last byte has moved into the result register. Results sit in an output
// register, so a stalled sink holds the current word and stops the readout.
// The idle timeout is written through the config channel, which is always ready;
// write it only while no word is in flight.
module uart_idle_gap_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uigf_in_if.sink     i_in,
    uigf_out_if.source  o_out,
    uigf_cfg_if.sink    i_cfg
);

    logic [uigf_pkg::ByteW-1:0] r_idle_timeout;

    // config write: capture the timeout on every handshake
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= uigf_pkg::IdleTimeoutReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_idle_timeout <= i_cfg.data;
        end
    end

    uigf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_idle_timeout (r_idle_timeout),
        .in_ch          (i_in),
        .out_ch         (o_out)
    );

endmodule

>>> hw/rtl/uigf_frame_ram.sv
// Simple dual-port frame store: one write port, one registered read port.
module uigf_frame_ram #(
    parameter int Width = 8,
    parameter int Depth = 64,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/uigf_ctrl.sv
// Frame receiver control: byte capture, idle timing, readout sequencer and result register.
module uigf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [uigf_pkg::ByteW-1:0]  i_idle_timeout,
    uigf_in_if.sink                     in_ch,
    uigf_out_if.source                  out_ch
);

    localparam logic StIdle = 1'b0;
    localparam logic StRead = 1'b1;

    localparam logic [uigf_pkg::IdxW-1:0] DepthIdx = uigf_pkg::IdxW'(uigf_pkg::BufferDepth);

    logic                         r_state, n_state;
    logic [uigf_pkg::IdxW-1:0]    r_wr_idx, n_wr_idx;
    logic [uigf_pkg::IdxW-1:0]    r_snap, n_snap;
    logic [uigf_pkg::ByteW-1:0]   r_idle, n_idle;
    logic                         r_recv, n_recv;
    logic                         r_ovf, n_ovf;
    logic [uigf_pkg::IdxW-1:0]    r_n, n_n;
    logic [uigf_pkg::IdxW-1:0]    r_issue, n_issue;
    logic                         r_pend, n_pend;
    logic                         r_pend_last, n_pend_last;
    logic                         r_out_valid, n_out_valid;
    uigf_pkg::t_result            r_out, n_out;

    logic                         out_free;
    logic                         accept;
    logic                         ld_pend;
    logic                         rd_issue;
    logic                         wr_en;
    logic [uigf_pkg::ByteW-1:0]   rd_data;
    logic [uigf_pkg::ByteW-1:0]   idle_sum;
    logic [uigf_pkg::ByteW-1:0]   idle_new;
    logic                         idle_fire;
    logic [uigf_pkg::IdxW-1:0]    read_n;

    assign out_free = !r_out_valid || out_ch.ready;
    assign in_ch.ready = (r_state == StIdle) && out_free;
    assign accept = in_ch.valid && in_ch.ready;

    assign ld_pend  = r_pend && out_free;
    assign rd_issue = (r_state == StRead) && (r_issue != r_n) && (!r_pend || out_free);
    assign wr_en    = accept && (in_ch.command == uigf_pkg::CmdRxByte) && (r_wr_idx < DepthIdx);

    uigf_frame_ram #(
        .Width (uigf_pkg::ByteW),
        .Depth (uigf_pkg::BufferDepth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wr_idx[uigf_pkg::AddrW-1:0]),
        .i_wdata (in_ch.rx_byte),
        .i_re    (rd_issue),
        .i_raddr (r_issue[uigf_pkg::AddrW-1:0]),
        .o_rdata (rd_data)
    );

    // idle timing: restart when bytes arrived since the previous tick
    assign idle_sum  = r_idle + in_ch.tick_ms;
    assign idle_new  = (r_snap != r_wr_idx) ? '0 : idle_sum;
    assign idle_fire = idle_new > i_idle_timeout;
    assign read_n    = (in_ch.read_limit < r_wr_idx) ? in_ch.read_limit : r_wr_idx;

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_snap      = r_snap;
        n_idle      = r_idle;
        n_recv      = r_recv;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && !out_ch.ready;
        n_out       = r_out;

        if (accept) begin
            unique case (in_ch.command)
                uigf_pkg::CmdRxByte: begin
                    if (r_wr_idx < DepthIdx) begin
                        n_wr_idx = r_wr_idx + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_recv = 1'b1;
                end
                uigf_pkg::CmdTick: begin
                    if (r_recv) begin
                        n_snap = r_wr_idx;
                        n_idle = idle_new;
                        if (idle_fire) begin
                            n_idle          = '0;
                            n_recv          = 1'b0;
                            n_out_valid     = 1'b1;
                            n_out.kind      = uigf_pkg::KindNotice;
                            n_out.data      = '0;
                            n_out.last      = 1'b1;
                            n_out.length    = r_wr_idx;
                            n_out.overflow  = r_ovf;
                        end
                    end
                end
                uigf_pkg::CmdRead: begin
                    n_wr_idx = '0;
                    if (read_n == '0) begin
                        n_out_valid    = 1'b1;
                        n_out.kind     = uigf_pkg::KindEmpty;
                        n_out.data     = '0;
                        n_out.last     = 1'b1;
                        n_out.length   = '0;
                        n_out.overflow = r_ovf;
                    end else begin
                        n_state = StRead;
                        n_n     = read_n;
                        n_issue = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        // move the fetched byte into the result register
        if (ld_pend) begin
            n_pend         = 1'b0;
            n_out_valid    = 1'b1;
            n_out.kind     = uigf_pkg::KindData;
            n_out.data     = rd_data;
            n_out.last     = r_pend_last;
            n_out.length   = r_n;
            n_out.overflow = r_ovf;
            if (r_pend_last) begin
                n_state = StIdle;
            end
        end

        if (rd_issue) begin
            n_pend      = 1'b1;
            n_pend_last = (r_issue == (r_n - 1'b1));
            n_issue     = r_issue + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_wr_idx    <= '0;
            r_snap      <= '0;
            r_idle      <= '0;
            r_recv      <= 1'b0;
            r_ovf       <= 1'b0;
            r_n         <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_snap      <= n_snap;
            r_idle      <= n_idle;
            r_recv      <= n_recv;
            r_ovf       <= n_ovf;
            r_n         <= n_n;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign out_ch.valid    = r_out_valid;
    assign out_ch.kind     = r_out.kind;
    assign out_ch.data     = r_out.data;
    assign out_ch.last     = r_out.last;
    assign out_ch.length   = r_out.length;
    assign out_ch.overflow = r_out.overflow;

endmodule
